/* design/hpi_pkg.sv */
package hpi_pkg;

	// Default frame store dimensions.
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Configuration register indexes.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Request commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Program step numbers and counter width.
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_WRITE = 4'd1;
	localparam step_t STEP_READ  = 4'd2;

	// Input request and result payloads.
	typedef struct packed {
		logic       cmd;
		logic [5:0] pos_x;
		logic [5:0] pos_y;
		logic [7:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [7:0] full_sample;
		logic [7:0] half_horizontal;
		logic [7:0] half_vertical;
	} res_t;

	// Micro-operations of the sequencer.
	typedef enum logic [1:0] {
		OP_IDLE,
		OP_WRITE,
		OP_TAP,
		OP_FINISH
	} op_t;

	// Filter weight codes.
	typedef enum logic [1:0] {
		W_P1,
		W_M5,
		W_P20
	} weight_t;

	// One control word of the program.
	typedef struct packed {
		op_t               op;
		logic              h_en;
		logic              v_en;
		logic signed [2:0] offset;
		weight_t           weight;
		step_t             nxt;
	} ctl_t;

	// Program store. The idle word dispatches on the command of an accepted request.
	// A read fetches the center pixel once, then five horizontal and five vertical
	// taps, and finishes by rounding both sums into the result register.
	function automatic ctl_t prog_word(input step_t step);
		ctl_t w;
		case (step)
			4'd0:    w = '{OP_IDLE,   1'b0, 1'b0,  3'sd0, W_P1,  STEP_IDLE};
			4'd1:    w = '{OP_WRITE,  1'b0, 1'b0,  3'sd0, W_P1,  STEP_IDLE};
			4'd2:    w = '{OP_TAP,    1'b1, 1'b1,  3'sd0, W_P20, 4'd3};
			4'd3:    w = '{OP_TAP,    1'b1, 1'b0, -3'sd2, W_P1,  4'd4};
			4'd4:    w = '{OP_TAP,    1'b1, 1'b0, -3'sd1, W_M5,  4'd5};
			4'd5:    w = '{OP_TAP,    1'b1, 1'b0,  3'sd1, W_P20, 4'd6};
			4'd6:    w = '{OP_TAP,    1'b1, 1'b0,  3'sd2, W_M5,  4'd7};
			4'd7:    w = '{OP_TAP,    1'b1, 1'b0,  3'sd3, W_P1,  4'd8};
			4'd8:    w = '{OP_TAP,    1'b0, 1'b1, -3'sd2, W_P1,  4'd9};
			4'd9:    w = '{OP_TAP,    1'b0, 1'b1, -3'sd1, W_M5,  4'd10};
			4'd10:   w = '{OP_TAP,    1'b0, 1'b1,  3'sd1, W_P20, 4'd11};
			4'd11:   w = '{OP_TAP,    1'b0, 1'b1,  3'sd2, W_M5,  4'd12};
			4'd12:   w = '{OP_TAP,    1'b0, 1'b1,  3'sd3, W_P1,  4'd13};
			4'd13:   w = '{OP_FINISH, 1'b0, 1'b0,  3'sd0, W_P1,  STEP_IDLE};
			default: w = '{OP_IDLE,   1'b0, 1'b0,  3'sd0, W_P1,  STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* design/halfpel_six_tap_interpolator.sv */
// Channel | Direction | Handshake           | Payload
// in      | request   | in_valid / in_stall | in_data   (cmd, pos_x, pos_y, pixel_in)
// out     | result    | out_valid/out_stall | out_data  (full, half horiz, half vert)
// cfg     | write     | cfg_we              | cfg_index, cfg_data
// A request is accepted only after the previous one ends: a write runs one write step, a read
// eleven fetches from the single-port frame memory, one per step, and then a finishing step.
// Reset sets both frame dimensions to 64; the frame memory is not cleared.
// The finishing step waits while a previous result is still stalled at the output.
module halfpel_six_tap_interpolator #(
	parameter int MAX_WIDTH  = hpi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hpi_pkg::DEF_MAX_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [6:0]     cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  hpi_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output hpi_pkg::res_t  out_data
);

	localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW          = $clog2(FRAME_DEPTH);

	// Clamp a tap coordinate into 0..lim.
	function automatic logic [5:0] clamp_tap(input logic [5:0] c,
		input logic signed [2:0] off, input logic [5:0] lim);
		logic signed [7:0] t;
		t = $signed({2'b00, c}) + $signed({{5{off[2]}}, off});
		if (t < 0) begin
			return 6'd0;
		end else if (t[6:0] > {1'b0, lim}) begin
			return lim;
		end
		return t[5:0];
	endfunction

	// Round by (sum + 16) >> 5 and saturate to 0..255.
	function automatic logic [7:0] round_sat(input logic signed [15:0] sum);
		logic signed [16:0] s;
		s = $signed({sum[15], sum}) + 17'sd16;
		if (s < 0) begin
			return 8'd0;
		end else if (s[16:5] > 12'd255) begin
			return 8'd255;
		end
		return s[12:5];
	endfunction

	logic [6:0]                width_q, height_q;
	logic [6:0]                eff_w, eff_h;
	logic [5:0]                wm, hm;
	hpi_pkg::step_t            pc_q;
	hpi_pkg::ctl_t             ctl, ctl_s1;
	logic                      in_accept;
	logic                      out_take;
	logic                      fin_go;
	logic [5:0]                x_q, y_q;
	logic [7:0]                pix_q;
	logic                      wr_ok_q;
	logic [5:0]                tap_x, tap_y;
	logic [AW-1:0]             mem_addr;
	logic [7:0]                frame_mem [FRAME_DEPTH];
	logic [7:0]                mem_rd_q;
	logic signed [15:0]        term;
	logic signed [15:0]        acc_h_q, acc_v_q, acc_h_nxt, acc_v_nxt;
	logic [7:0]                full_q;
	logic                      out_valid_q;
	hpi_pkg::res_t             out_data_q;
	logic [15:0]               d16, p5, p20;

	// Effective frame size: zero acts as one, anything above the store acts as its maximum.
	assign eff_w = (width_q == 7'd0) ? 7'd1 :
		((32'(width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_q);
	assign eff_h = (height_q == 7'd0) ? 7'd1 :
		((32'(height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_q);
	assign wm = 6'(eff_w - 7'd1);
	assign hm = 6'(eff_h - 7'd1);

	// Current control word and handshake.
	assign ctl       = hpi_pkg::prog_word(pc_q);
	assign in_stall  = (ctl.op != hpi_pkg::OP_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign fin_go    = (ctl.op == hpi_pkg::OP_FINISH) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Tap coordinates and frame address for this step.
	assign tap_x    = ctl.h_en ? clamp_tap(x_q, ctl.offset, wm) : x_q;
	assign tap_y    = ctl.v_en ? clamp_tap(y_q, ctl.offset, hm) : y_q;
	assign mem_addr = AW'(tap_y) * AW'(MAX_WIDTH) + AW'(tap_x);

	// Weighted tap from the pixel fetched in the previous step.
	assign d16 = {8'd0, mem_rd_q};
	assign p5  = (d16 << 2) + d16;
	assign p20 = p5 << 2;
	always_comb begin
		case (ctl_s1.weight)
			hpi_pkg::W_P1:  term = $signed(d16);
			hpi_pkg::W_M5:  term = -$signed(p5);
			hpi_pkg::W_P20: term = $signed(p20);
			default:        term = 16'sd0;
		endcase
	end

	// Accumulator inputs; the finishing step rounds these so the last tap is included.
	assign acc_h_nxt = (ctl_s1.op == hpi_pkg::OP_TAP && ctl_s1.h_en) ?
		acc_h_q + term : acc_h_q;
	assign acc_v_nxt = (ctl_s1.op == hpi_pkg::OP_TAP && ctl_s1.v_en) ?
		acc_v_q + term : acc_v_q;

	// Sequencer, configuration registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= hpi_pkg::STEP_IDLE;
			ctl_s1      <= hpi_pkg::prog_word(hpi_pkg::STEP_IDLE);
			out_valid_q <= 1'b0;
			width_q     <= 7'd64;
			height_q    <= 7'd64;
		end else begin
			ctl_s1 <= ctl;
			if (cfg_we) begin
				case (cfg_index)
					hpi_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					hpi_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			case (ctl.op)
				hpi_pkg::OP_IDLE: begin
					if (in_accept) begin
						pc_q <= (in_data.cmd == hpi_pkg::CMD_READ) ?
							hpi_pkg::STEP_READ : hpi_pkg::STEP_WRITE;
					end
				end
				hpi_pkg::OP_FINISH: begin
					if (fin_go) begin
						pc_q <= ctl.nxt;
					end
				end
				default: pc_q <= ctl.nxt;
			endcase
			// A new result sets valid; a taken result with none behind it clears it.
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request registers, accumulators and result register.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q     <= (in_data.pos_x > wm) ? wm : in_data.pos_x;
			y_q     <= (in_data.pos_y > hm) ? hm : in_data.pos_y;
			pix_q   <= in_data.pixel_in;
			wr_ok_q <= ({1'b0, in_data.pos_x} < eff_w) && ({1'b0, in_data.pos_y} < eff_h);
			acc_h_q <= 16'sd0;
			acc_v_q <= 16'sd0;
		end else begin
			acc_h_q <= acc_h_nxt;
			acc_v_q <= acc_v_nxt;
		end
		if (ctl_s1.op == hpi_pkg::OP_TAP && ctl_s1.h_en && ctl_s1.v_en) begin
			full_q <= mem_rd_q;
		end
		if (fin_go) begin
			out_data_q.full_sample     <= full_q;
			out_data_q.half_horizontal <= round_sat(acc_h_nxt);
			out_data_q.half_vertical   <= round_sat(acc_v_nxt);
		end
	end

	// Single-port frame memory with registered read.
	always_ff @(posedge clk) begin
		if (ctl.op == hpi_pkg::OP_WRITE && wr_ok_q) begin
			frame_mem[mem_addr] <= pix_q;
		end
		mem_rd_q <= frame_mem[mem_addr];
	end

endmodule

/* tb/halfpel_six_tap_interpolator_tb.sv */
`timescale 1ns / 1ps

module halfpel_six_tap_interpolator_tb;

	localparam int FRAME_DIM = 64;

	// Keeps a copy of the frame and the frame registers, and predicts the samples of each read.
	class halfpel_predictor;
		bit [7:0] pixels [FRAME_DIM*FRAME_DIM];
		bit       written [FRAME_DIM*FRAME_DIM];
		bit [6:0] width_reg;
		bit [6:0] height_reg;
		hpi_pkg::res_t pending_samples [$];
		int       mismatches;
		int       kernel [6] = '{1, -5, 20, 20, -5, 1};

		function new();
			width_reg = 7'd64;
			height_reg = 7'd64;
			mismatches = 0;
		endfunction

		// A zero register acts as one, and anything above the store size acts as the maximum.
		function int eff_dim(bit [6:0] r);
			if (r == 0) return 1;
			if (r > FRAME_DIM) return FRAME_DIM;
			return r;
		endfunction

		function void set_reg(logic idx, bit [6:0] value);
			if (idx == hpi_pkg::REG_FRAME_WIDTH) width_reg = value;
			else height_reg = value;
		endfunction

		function int clip(int v, int hi);
			if (v < 0) return 0;
			if (v > hi) return hi;
			return v;
		endfunction

		function bit [7:0] pel(int x, int y);
			return pixels[y*FRAME_DIM + x];
		endfunction

		function bit [7:0] round_clip(int sum);
			int s;
			s = sum + 16;
			if (s < 0) return 8'd0;
			s = s >>> 5;
			if (s > 255) return 8'd255;
			return s[7:0];
		endfunction

		// Six-tap filter in both directions around the clamped query position.
		function hpi_pkg::res_t interpolate(int qx, int qy);
			hpi_pkg::res_t r;
			int wm, hm, x, y, hsum, vsum;
			wm = eff_dim(width_reg) - 1;
			hm = eff_dim(height_reg) - 1;
			x = clip(qx, wm);
			y = clip(qy, hm);
			hsum = 0;
			vsum = 0;
			for (int t = 0; t < 6; t++) begin
				hsum += kernel[t] * int'(pel(clip(x + t - 2, wm), y));
				vsum += kernel[t] * int'(pel(x, clip(y + t - 2, hm)));
			end
			r.full_sample = pel(x, y);
			r.half_horizontal = round_clip(hsum);
			r.half_vertical = round_clip(vsum);
			return r;
		endfunction

		// An accepted write updates the frame when it lands inside it; a read expects a result.
		function void note_request(hpi_pkg::req_t r);
			if (r.cmd == hpi_pkg::CMD_WRITE) begin
				if (r.pos_x < eff_dim(width_reg) && r.pos_y < eff_dim(height_reg)) begin
					pixels[r.pos_y*FRAME_DIM + r.pos_x] = r.pixel_in;
					written[r.pos_y*FRAME_DIM + r.pos_x] = 1'b1;
				end
			end else begin
				pending_samples.push_back(interpolate(r.pos_x, r.pos_y));
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(hpi_pkg::res_t got);
			hpi_pkg::res_t want;
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = pending_samples.pop_front();
				if (got.full_sample !== want.full_sample)
					report_mismatch($sformatf("full_sample %h, expected %h",
						got.full_sample, want.full_sample));
				if (got.half_horizontal !== want.half_horizontal)
					report_mismatch($sformatf("half_horizontal %h, expected %h",
						got.half_horizontal, want.half_horizontal));
				if (got.half_vertical !== want.half_vertical)
					report_mismatch($sformatf("half_vertical %h, expected %h",
						got.half_vertical, want.half_vertical));
			end
		endtask

		function int pending();
			return pending_samples.size();
		endfunction

		task close_out();
			if (pending_samples.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_samples.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [6:0] cfg_data;
	logic in_valid;
	logic in_stall;
	hpi_pkg::req_t in_data;
	logic out_valid;
	logic out_stall;
	hpi_pkg::res_t out_data;

	halfpel_predictor sb;
	bit calm;
	int results_seen;

	halfpel_six_tap_interpolator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic hpi_pkg::req_t make_req(logic c, int x, int y, int p);
		hpi_pkg::req_t r;
		r.cmd = c;
		r.pos_x = x[5:0];
		r.pos_y = y[5:0];
		r.pixel_in = p[7:0];
		return r;
	endfunction

	// Pixel values lean toward the extremes so that both saturation limits are hit.
	function automatic int rand_pel();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Offers one request, with an occasional idle burst in front of it.
	task automatic send_req(input hpi_pkg::req_t r);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = r;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	// Writes any still-empty pixel under the filter taps of a read, then offers the read.
	task automatic send_read(input int qx, input int qy, input int p);
		int wm, hm, cx, cy, tx, ty;
		wm = sb.eff_dim(sb.width_reg) - 1;
		hm = sb.eff_dim(sb.height_reg) - 1;
		cx = sb.clip(qx, wm);
		cy = sb.clip(qy, hm);
		for (int t = -2; t <= 3; t++) begin
			tx = sb.clip(cx + t, wm);
			ty = sb.clip(cy + t, hm);
			if (!sb.written[cy*FRAME_DIM + tx])
				send_req(make_req(hpi_pkg::CMD_WRITE, tx, cy, rand_pel()));
			if (!sb.written[ty*FRAME_DIM + cx])
				send_req(make_req(hpi_pkg::CMD_WRITE, cx, ty, rand_pel()));
		end
		send_req(make_req(hpi_pkg::CMD_READ, qx, qy, p));
	endtask

	// Stops offering, waits for all results and lets a trailing write finish.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[6:0];
		sb.set_reg(idx, value[6:0]);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_frame(input int w, input int h);
		drain();
		write_reg(hpi_pkg::REG_FRAME_WIDTH, w);
		write_reg(hpi_pkg::REG_FRAME_HEIGHT, h);
	endtask

	// Writes every pixel of the active frame that holds no value yet, so reads never touch one.
	task automatic fill_frame();
		for (int y = 0; y < sb.eff_dim(sb.height_reg); y++)
			for (int x = 0; x < sb.eff_dim(sb.width_reg); x++)
				if (!sb.written[y*FRAME_DIM + x])
					send_req(make_req(hpi_pkg::CMD_WRITE, x, y, rand_pel()));
	endtask

	// Result side: random stall bursts, one long hold-off, and the check of each result.
	initial begin
		int stall_left;
		bit held;
		out_stall = 1'b0;
		stall_left = 0;
		held = 1'b0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(out_data);
				results_seen++;
			end
			@(negedge clk);
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Request side.
	initial begin
		int w, h, weff, heff, x, y;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hpi_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-pixel frame: every tap clamps onto one pixel, and out-of-frame writes are dropped.
		set_frame(1, 1);
		send_req(make_req(hpi_pkg::CMD_WRITE, 0, 0, 255));
		send_req(make_req(hpi_pkg::CMD_READ, 0, 0, 0));
		send_req(make_req(hpi_pkg::CMD_READ, 63, 63, 255));
		send_req(make_req(hpi_pkg::CMD_WRITE, 63, 63, 0));
		send_req(make_req(hpi_pkg::CMD_READ, 0, 0, 0));
		send_req(make_req(hpi_pkg::CMD_WRITE, 0, 0, 0));
		send_req(make_req(hpi_pkg::CMD_READ, 63, 0, 255));

		// Zero dimensions act as one.
		set_frame(0, 0);
		send_req(make_req(hpi_pkg::CMD_READ, 5, 5, 0));

		// Patterns that drive both half-pel sums below zero and above the maximum.
		set_frame(6, 6);
		fill_frame();
		for (x = 0; x < 6; x++) begin
			send_req(make_req(hpi_pkg::CMD_WRITE, x, 2, (x == 2 || x == 3) ? 0 : 255));
			send_req(make_req(hpi_pkg::CMD_WRITE, x, 4, (x == 2 || x == 3) ? 255 : 0));
		end
		send_req(make_req(hpi_pkg::CMD_READ, 2, 2, 0));
		send_req(make_req(hpi_pkg::CMD_READ, 2, 4, 0));
		send_req(make_req(hpi_pkg::CMD_READ, 2, 3, 0));

		// Oversized registers act as the full store; read the corners.
		set_frame(127, 127);
		send_read(0, 0, 0);
		send_read(63, 63, 0);
		send_read(63, 0, 0);
		send_read(0, 63, 0);

		// Random phases, each under its own frame size; the last one runs without idling.
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin w = 64; h = 1; end
				1: begin w = 1; h = 64; end
				2: begin w = 127; h = 0; end
				3: begin w = 64; h = 64; end
				default: begin
					w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
					h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
				end
			endcase
			set_frame(w, h);
			calm = (phase == 9);
			weff = sb.eff_dim(sb.width_reg);
			heff = sb.eff_dim(sb.height_reg);
			for (int n = 0; n < 35; n++) begin
				if ($urandom_range(0, 1) == 0) begin
					x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, weff - 1);
					y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, heff - 1);
					send_read(x, y, $urandom_range(0, 255));
				end else if ($urandom_range(0, 6) == 0) begin
					send_req(make_req(hpi_pkg::CMD_WRITE, $urandom_range(0, 63),
						$urandom_range(0, 63), rand_pel()));
				end else begin
					send_req(make_req(hpi_pkg::CMD_WRITE, $urandom_range(0, weff - 1),
						$urandom_range(0, heff - 1), rand_pel()));
				end
			end
		end

		drain();
		sb.close_out();
		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
